// ----- design/mlbc_pkg.sv -----
// Shared types and codes for the multi-LED blink controller.
`default_nettype none
package mlbc_pkg;

    localparam int unsigned INDEX_WIDTH  = 3;
    localparam int unsigned FIELD_WIDTH  = 16;
    localparam int unsigned LEVELS_WIDTH = 8;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_DONE
    } ctl_state_t;

endpackage
`default_nettype wire

// ----- design/multi_led_blink_controller.sv -----
// Top level of the multi-LED blink controller: entry memory, tick sweep and result register.
`default_nettype none
// Each beat on the s_ side is either a tick or a set command for one LED, and each one
// returns exactly one beat on the m_ side carrying the levels of LEDs 0 to 7 afterwards.
// Countdown, on interval and off interval of every LED live in one memory with one
// registered read port; levels and written-once flags sit in flops, so reset takes effect
// at once with no clearing pass. A set command writes its entry directly. A tick sweeps
// the memory one LED per cycle through that single read port, writing each updated
// entry back in the cycle after its read. A finished result waits in the output register;
// the next beat is taken once the result of the previous one has been loaded there.
module multi_led_blink_controller #(
    parameter int unsigned NUM_LEDS   = 8,
    parameter int unsigned TICK_WIDTH = 16
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire                                 s_opcode,
    input  wire  [mlbc_pkg::INDEX_WIDTH-1:0]    s_led_index,
    input  wire                                 s_led_level,
    input  wire  [mlbc_pkg::FIELD_WIDTH-1:0]    s_on_ticks,
    input  wire  [mlbc_pkg::FIELD_WIDTH-1:0]    s_off_ticks,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic [mlbc_pkg::LEVELS_WIDTH-1:0]   m_led_levels
);
    import mlbc_pkg::*;

    localparam int unsigned AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int unsigned CW = $clog2(NUM_LEDS + 1);
    localparam int unsigned TW = TICK_WIDTH;
    localparam int unsigned EW = 3 * TW;

    // entry layout: {countdown, on interval, off interval}
    logic [EW-1:0] mem [NUM_LEDS];

    ctl_state_t state_reg, state_next;

    logic [NUM_LEDS-1:0]     lit_reg, lit_next;
    logic [NUM_LEDS-1:0]     vld_reg, vld_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic                    stage_vld_reg, stage_vld_next;
    logic [AW-1:0]           stage_idx_reg, stage_idx_next;
    logic                    m_valid_reg, m_valid_next;
    logic [LEVELS_WIDTH-1:0] m_levels_reg, m_levels_next;
    logic [EW-1:0]           rd_data_reg;

    logic          s_beat;
    logic          out_free;
    logic          issue;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    logic [31:0]   idx_wide;
    logic [31:0]   on_wide;
    logic [31:0]   off_wide;
    logic [TW-1:0] set_on;
    logic [TW-1:0] set_off;
    logic          set_in_range;

    logic [EW-1:0] cur_entry;
    logic [TW-1:0] cur_cd;
    logic [TW-1:0] cur_on;
    logic [TW-1:0] cur_off;
    logic [TW-1:0] dec_cd;
    logic [TW-1:0] new_cd;
    logic          cur_lit;
    logic          new_lit;
    logic [LEVELS_WIDTH-1:0] levels_now;

    assign s_ready      = (state_reg == ST_IDLE);
    assign s_beat       = s_valid && s_ready;
    assign out_free     = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_led_levels = m_levels_reg;

    assign issue   = (state_reg == ST_TICK) && (32'(cnt_reg) < NUM_LEDS);
    assign rd_addr = cnt_reg[AW-1:0];

    // set command fields, masked to the interval width
    always_comb begin
        idx_wide     = 32'(s_led_index);
        on_wide      = 32'(s_on_ticks);
        off_wide     = 32'(s_off_ticks);
        set_on       = on_wide[TW-1:0];
        set_off      = (off_wide[TW-1:0] == '0) ? on_wide[TW-1:0] : off_wide[TW-1:0];
        set_in_range = idx_wide < NUM_LEDS;
    end

    // per-LED update for the entry read last cycle
    always_comb begin
        cur_entry = vld_reg[stage_idx_reg] ? rd_data_reg : '0;
        cur_cd    = cur_entry[EW-1 -: TW];
        cur_on    = cur_entry[2*TW-1 -: TW];
        cur_off   = cur_entry[TW-1:0];
        cur_lit   = lit_reg[stage_idx_reg];
        dec_cd    = (cur_cd > TW'(1)) ? cur_cd - TW'(1) : cur_cd;
        new_cd    = dec_cd;
        new_lit   = cur_lit;
        if ((dec_cd <= TW'(1)) && (cur_on != '0)) begin
            new_lit = !cur_lit;
            new_cd  = cur_lit ? cur_off : cur_on;
        end
    end

    always_comb begin
        levels_now = '0;
        for (int unsigned k = 0; k < LEVELS_WIDTH; k++) begin
            if (k < NUM_LEDS) begin
                levels_now[k] = lit_reg[k];
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_beat) begin
                    state_next = (s_opcode == OP_SET) ? ST_DONE : ST_TICK;
                end
            end
            ST_TICK: begin
                if (!issue && !stage_vld_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        lit_next       = lit_reg;
        vld_next       = vld_reg;
        cnt_next       = cnt_reg;
        stage_vld_next = 1'b0;
        stage_idx_next = stage_idx_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_levels_next  = m_levels_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_wide[AW-1:0];
        wr_data        = {set_on, set_on, set_off};
        case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (s_beat && (s_opcode == OP_SET) && set_in_range) begin
                    wr_en              = 1'b1;
                    lit_next[wr_addr]  = s_led_level;
                    vld_next[wr_addr]  = 1'b1;
                end
            end
            ST_TICK: begin
                if (issue) begin
                    cnt_next       = cnt_reg + CW'(1);
                    stage_vld_next = 1'b1;
                    stage_idx_next = rd_addr;
                end
                // write back only entries that hold data; others still read as zero
                if (stage_vld_reg) begin
                    lit_next[stage_idx_reg] = new_lit;
                    if (vld_reg[stage_idx_reg]) begin
                        wr_en   = 1'b1;
                        wr_addr = stage_idx_reg;
                        wr_data = {new_cd, cur_on, cur_off};
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_levels_next = levels_now;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            lit_reg       <= '0;
            vld_reg       <= '0;
            cnt_reg       <= '0;
            stage_vld_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            lit_reg       <= lit_next;
            vld_reg       <= vld_next;
            cnt_reg       <= cnt_next;
            stage_vld_reg <= stage_vld_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        stage_idx_reg <= stage_idx_next;
        m_levels_reg  <= m_levels_next;
    end

endmodule
`default_nettype wire

// ----- sim/mlbc_levels_checker.sv -----
// Checker for the multi-LED blink controller: tracks every LED's blink state and checks each result beat.
`timescale 1ns / 1ps
module mlbc_levels_checker (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_valid,
    input  wire                                 s_ready,
    input  wire                                 s_opcode,
    input  wire  [mlbc_pkg::INDEX_WIDTH-1:0]    s_led_index,
    input  wire                                 s_led_level,
    input  wire  [mlbc_pkg::FIELD_WIDTH-1:0]    s_on_ticks,
    input  wire  [mlbc_pkg::FIELD_WIDTH-1:0]    s_off_ticks,
    input  wire                                 m_valid,
    input  wire                                 m_ready,
    input  wire  [mlbc_pkg::LEVELS_WIDTH-1:0]   m_led_levels,
    output int                                  mismatches,
    output int                                  pending,
    output int                                  checked
);
    import mlbc_pkg::*;

    localparam int LED_COUNT    = 8;
    localparam int REPORT_LIMIT = 10;

    logic                      lit_q     [LED_COUNT];
    logic [FIELD_WIDTH-1:0]    count_q   [LED_COUNT];
    logic [FIELD_WIDTH-1:0]    on_q      [LED_COUNT];
    logic [FIELD_WIDTH-1:0]    off_q     [LED_COUNT];
    logic [LEVELS_WIDTH-1:0]   expected_levels [$];

    initial begin
        mismatches = 0;
        pending    = 0;
        checked    = 0;
    end

    function automatic void clear_bank();
        for (int k = 0; k < LED_COUNT; k++) begin
            lit_q[k]   = 1'b0;
            count_q[k] = '0;
            on_q[k]    = '0;
            off_q[k]   = '0;
        end
    endfunction

    // Count down first, then toggle any blinking LED whose countdown has run out.
    function automatic void advance_tick();
        for (int k = 0; k < LED_COUNT; k++) begin
            if (count_q[k] > 1)
                count_q[k] = count_q[k] - 1'b1;
            if (count_q[k] <= 1 && on_q[k] != '0) begin
                if (lit_q[k]) begin
                    lit_q[k]   = 1'b0;
                    count_q[k] = off_q[k];
                end else begin
                    lit_q[k]   = 1'b1;
                    count_q[k] = on_q[k];
                end
            end
        end
    endfunction

    function automatic void program_led(logic [INDEX_WIDTH-1:0] idx, logic lvl,
                                        logic [FIELD_WIDTH-1:0] on_t,
                                        logic [FIELD_WIDTH-1:0] off_t);
        if (idx >= LED_COUNT)
            return;
        lit_q[idx]   = lvl;
        on_q[idx]    = on_t;
        off_q[idx]   = (off_t == '0) ? on_t : off_t;
        count_q[idx] = on_t;
    endfunction

    function automatic logic [LEVELS_WIDTH-1:0] levels_now();
        logic [LEVELS_WIDTH-1:0] w;
        w = '0;
        for (int k = 0; k < LED_COUNT && k < LEVELS_WIDTH; k++)
            w[k] = lit_q[k];
        return w;
    endfunction

    always @(posedge aclk) begin
        logic [LEVELS_WIDTH-1:0] want;
        if (!aresetn) begin
            clear_bank();
            expected_levels.delete();
            pending <= 0;
        end else begin
            if (s_valid && s_ready) begin
                if (s_opcode == OP_SET)
                    program_led(s_led_index, s_led_level, s_on_ticks, s_off_ticks);
                else
                    advance_tick();
                expected_levels.push_back(levels_now());
            end
            if (m_valid && m_ready) begin
                if (expected_levels.size() == 0) begin
                    if (mismatches < REPORT_LIMIT)
                        $display("%0t: result beat %02h arrived with nothing expected",
                                 $realtime, m_led_levels);
                    mismatches <= mismatches + 1;
                end else begin
                    want = expected_levels.pop_front();
                    if (m_led_levels !== want) begin
                        if (mismatches < REPORT_LIMIT)
                            $display("%0t: led_levels on beat %0d: expected %02h, got %02h",
                                     $realtime, checked, want, m_led_levels);
                        mismatches <= mismatches + 1;
                    end
                end
                checked <= checked + 1;
            end
            pending <= expected_levels.size();
        end
    end

endmodule

// ----- sim/multi_led_blink_controller_tb.sv -----
// Testbench top for the multi-LED blink controller: stimulus, handshake pressure and verdict.
`timescale 1ns / 1ps
module multi_led_blink_controller_tb;
    import mlbc_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 24;
    localparam int PHASE_BEATS  = 475;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic                      s_opcode = OP_TICK;
    logic [INDEX_WIDTH-1:0]    s_led_index = '0;
    logic                      s_led_level = 1'b0;
    logic [FIELD_WIDTH-1:0]    s_on_ticks = '0;
    logic [FIELD_WIDTH-1:0]    s_off_ticks = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [LEVELS_WIDTH-1:0]   m_led_levels;

    int mismatches;
    int pending;
    int checked;
    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    int tick_count = 0;
    int set_count = 0;

    multi_led_blink_controller dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_led_index  (s_led_index),
        .s_led_level  (s_led_level),
        .s_on_ticks   (s_on_ticks),
        .s_off_ticks  (s_off_ticks),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_led_levels (m_led_levels)
    );

    mlbc_levels_checker levels_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_led_index  (s_led_index),
        .s_led_level  (s_led_level),
        .s_on_ticks   (s_on_ticks),
        .s_off_ticks  (s_off_ticks),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_led_levels (m_led_levels),
        .mismatches   (mismatches),
        .pending      (pending),
        .checked      (checked)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge aclk);
        $display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Hold valid across back-to-back beats; drop it only when the sender goes idle.
    task automatic send_beat(logic op, logic [INDEX_WIDTH-1:0] idx, logic lvl,
                             logic [FIELD_WIDTH-1:0] on_t, logic [FIELD_WIDTH-1:0] off_t);
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < idle_pct)
                @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_opcode    <= op;
        s_led_index <= idx;
        s_led_level <= lvl;
        s_on_ticks  <= on_t;
        s_off_ticks <= off_t;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (op == OP_SET)
            set_count++;
        else
            tick_count++;
    endtask

    task automatic send_tick();
        send_beat(OP_TICK, INDEX_WIDTH'($urandom), 1'($urandom),
                  FIELD_WIDTH'($urandom), FIELD_WIDTH'($urandom));
    endtask

    // Mostly ticks and short blink programs so LEDs actually toggle; a few wide values.
    task automatic send_random_beat();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            send_tick();
        else if (roll < 90)
            send_beat(OP_SET, INDEX_WIDTH'($urandom), 1'($urandom),
                      FIELD_WIDTH'($urandom_range(0, 6)), FIELD_WIDTH'($urandom_range(0, 6)));
        else
            send_beat(OP_SET, INDEX_WIDTH'($urandom), 1'($urandom),
                      FIELD_WIDTH'($urandom), FIELD_WIDTH'($urandom));
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: tick from reset, off interval defaulting, steady LEDs, field extremes.
        send_tick();
        send_beat(OP_SET, 3'd0, 1'b1, 16'd1, 16'd0);
        send_beat(OP_SET, 3'd1, 1'b0, 16'd0, 16'hFFFF);
        send_beat(OP_SET, 3'd2, 1'b1, 16'hFFFF, 16'hFFFF);
        send_beat(OP_SET, 3'd3, 1'b0, 16'd2, 16'd3);
        send_beat(OP_SET, 3'd4, 1'b0, 16'd1, 16'd2);
        send_beat(OP_SET, 3'd5, 1'b1, 16'd3, 16'd0);
        send_beat(OP_SET, 3'd6, 1'b0, 16'hAAAA, 16'h5555);
        send_beat(OP_SET, 3'd7, 1'b1, 16'd0, 16'd0);
        repeat (8) send_tick();
        send_beat(OP_SET, 3'd0, 1'b0, 16'd0, 16'd0);
        send_beat(OP_SET, 3'd6, 1'b1, 16'h5555, 16'hAAAA);
        repeat (2) send_tick();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 55; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 55; end
                default: begin idle_pct = 27; stall_pct = 27; end
            endcase
            repeat (PHASE_BEATS) send_random_beat();
        end
        s_valid <= 1'b0;
        // let the checker count the last accepted beat before reading pending
        @(posedge aclk);

        while (pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d ticks and %0d set commands across four pressure phases;",
                 tick_count, set_count);
        $display("checked %0d result beats, %0d mismatching.", checked, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
